### rtl/core/stt_pkg.sv
`timescale 1ns / 1ps

package stt_pkg;

  // Field widths fixed by the token format
  localparam int BYTE_BITS     = 8;
  localparam int KIND_BITS     = 6;
  localparam int START_BITS    = 16;
  localparam int LEN_BITS      = 16;
  localparam int IN_DATA_BITS  = 8;
  localparam int OUT_DATA_BITS = 40;
  localparam int KW_COUNT      = 15;
  localparam int KW_SPELL_MAX  = 7;
  localparam int Q_DEPTH       = 4;
  localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  typedef logic [KIND_BITS-1:0] kind_t;
  typedef logic [BYTE_BITS-1:0] byte_t;

  // Token kinds
  localparam kind_t K_ILLEGAL   = 6'd0;
  localparam kind_t K_END       = 6'd1;
  localparam kind_t K_IDENT     = 6'd2;
  localparam kind_t K_INT_LIT   = 6'd3;
  localparam kind_t K_FLOAT_LIT = 6'd4;
  localparam kind_t K_KW_INT    = 6'd5;
  localparam kind_t K_KW_FLOAT  = 6'd6;
  localparam kind_t K_KW_CHAR   = 6'd7;
  localparam kind_t K_KW_BOOL   = 6'd8;
  localparam kind_t K_KW_VARCHR = 6'd9;
  localparam kind_t K_KW_VI     = 6'd10;
  localparam kind_t K_KW_VOID   = 6'd11;
  localparam kind_t K_KW_FOR    = 6'd12;
  localparam kind_t K_KW_WHILE  = 6'd13;
  localparam kind_t K_KW_IF     = 6'd14;
  localparam kind_t K_KW_ELSE   = 6'd15;
  localparam kind_t K_KW_RETURN = 6'd16;
  localparam kind_t K_KW_TRUE   = 6'd17;
  localparam kind_t K_KW_FALSE  = 6'd18;
  localparam kind_t K_ASSIGN    = 6'd19;
  localparam kind_t K_EQ        = 6'd20;
  localparam kind_t K_PLUS      = 6'd21;
  localparam kind_t K_MINUS     = 6'd22;
  localparam kind_t K_NOT       = 6'd23;
  localparam kind_t K_NE        = 6'd24;
  localparam kind_t K_DIV       = 6'd25;
  localparam kind_t K_MUL       = 6'd26;
  localparam kind_t K_LT        = 6'd27;
  localparam kind_t K_LE        = 6'd28;
  localparam kind_t K_GT        = 6'd29;
  localparam kind_t K_GE        = 6'd30;
  localparam kind_t K_AND       = 6'd31;
  localparam kind_t K_OR        = 6'd32;
  localparam kind_t K_SEMI      = 6'd33;
  localparam kind_t K_COMMA     = 6'd34;
  localparam kind_t K_COLON     = 6'd35;
  localparam kind_t K_LPAREN    = 6'd36;
  localparam kind_t K_RPAREN    = 6'd37;
  localparam kind_t K_LBRACE    = 6'd38;
  localparam kind_t K_RBRACE    = 6'd39;
  localparam kind_t K_LBRACKET  = 6'd40;
  localparam kind_t K_RBRACKET  = 6'd41;
  localparam kind_t KIND_LAST   = K_RBRACKET;

  // Characters
  localparam byte_t CH_NUL    = 8'h00;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_BANG   = 8'h21;
  localparam byte_t CH_AMP    = 8'h26;
  localparam byte_t CH_LPAREN = 8'h28;
  localparam byte_t CH_RPAREN = 8'h29;
  localparam byte_t CH_STAR   = 8'h2A;
  localparam byte_t CH_PLUS   = 8'h2B;
  localparam byte_t CH_COMMA  = 8'h2C;
  localparam byte_t CH_MINUS  = 8'h2D;
  localparam byte_t CH_DOT    = 8'h2E;
  localparam byte_t CH_SLASH  = 8'h2F;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_NINE   = 8'h39;
  localparam byte_t CH_COLON  = 8'h3A;
  localparam byte_t CH_SEMI   = 8'h3B;
  localparam byte_t CH_LT     = 8'h3C;
  localparam byte_t CH_EQUAL  = 8'h3D;
  localparam byte_t CH_GT     = 8'h3E;
  localparam byte_t CH_UP_A   = 8'h41;
  localparam byte_t CH_UP_Z   = 8'h5A;
  localparam byte_t CH_LBRACK = 8'h5B;
  localparam byte_t CH_RBRACK = 8'h5D;
  localparam byte_t CH_UNDER  = 8'h5F;
  localparam byte_t CH_LO_A   = 8'h61;
  localparam byte_t CH_LO_Z   = 8'h7A;
  localparam byte_t CH_LBRACE = 8'h7B;
  localparam byte_t CH_BAR    = 8'h7C;
  localparam byte_t CH_RBRACE = 8'h7D;

  // Scanner modes; operator modes hold a first character awaiting its second
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_WORD    = 4'd1,
    MODE_INT     = 4'd2,
    MODE_FRAC    = 4'd3,
    MODE_OP_EQ   = 4'd4,
    MODE_OP_BANG = 4'd5,
    MODE_OP_LT   = 4'd6,
    MODE_OP_GT   = 4'd7,
    MODE_OP_AMP  = 4'd8,
    MODE_OP_BAR  = 4'd9
  } mode_t;

  typedef struct packed {
    kind_t                 kind;
    logic [START_BITS-1:0] start;
    logic [LEN_BITS-1:0]   len;
  } tok_t;

  // One queue record: the tokens caused by one input byte
  typedef struct packed {
    logic two;
    tok_t t1;
    tok_t t0;
  } rec_t;

  // Keyword spellings, right-justified in the word
  localparam logic [8*KW_SPELL_MAX-1:0] KW_TEXT [KW_COUNT] = '{
    "int", "float", "char", "bool", "varchar", "vi", "void", "for",
    "forn", "while", "if", "else", "return", "true", "false"
  };
  localparam int KW_LEN [KW_COUNT] = '{3, 5, 4, 4, 7, 2, 4, 3, 4, 5, 2, 4, 6, 4, 5};
  localparam kind_t KW_KIND [KW_COUNT] = '{
    K_KW_INT, K_KW_FLOAT, K_KW_CHAR, K_KW_BOOL, K_KW_VARCHR, K_KW_VI, K_KW_VOID,
    K_KW_FOR, K_KW_FOR, K_KW_WHILE, K_KW_IF, K_KW_ELSE, K_KW_RETURN, K_KW_TRUE,
    K_KW_FALSE
  };

  function automatic logic is_letter(input byte_t b);
    return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
           (b == CH_UNDER);
  endfunction

  function automatic logic is_digit(input byte_t b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic is_space(input byte_t b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic kind_t single_op_kind(input byte_t b);
    kind_t k;
    unique case (b)
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_SLASH:  k = K_DIV;
      CH_STAR:   k = K_MUL;
      CH_SEMI:   k = K_SEMI;
      CH_COMMA:  k = K_COMMA;
      CH_COLON:  k = K_COLON;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LBRACK: k = K_LBRACKET;
      CH_RBRACK: k = K_RBRACKET;
      default:   k = K_ILLEGAL;
    endcase
    return k;
  endfunction

  // Mode entered by a character that may start a two-character operator
  function automatic mode_t op_mode_of(input byte_t b);
    mode_t m;
    unique case (b)
      CH_EQUAL: m = MODE_OP_EQ;
      CH_BANG:  m = MODE_OP_BANG;
      CH_LT:    m = MODE_OP_LT;
      CH_GT:    m = MODE_OP_GT;
      CH_AMP:   m = MODE_OP_AMP;
      CH_BAR:   m = MODE_OP_BAR;
      default:  m = MODE_IDLE;
    endcase
    return m;
  endfunction

  function automatic logic is_op_mode(input mode_t m);
    return m >= MODE_OP_EQ && m <= MODE_OP_BAR;
  endfunction

  function automatic byte_t op_second(input mode_t m);
    byte_t c;
    unique case (m)
      MODE_OP_AMP: c = CH_AMP;
      MODE_OP_BAR: c = CH_BAR;
      default:     c = CH_EQUAL;
    endcase
    return c;
  endfunction

  function automatic kind_t op_single_kind(input mode_t m);
    kind_t k;
    unique case (m)
      MODE_OP_EQ:   k = K_ASSIGN;
      MODE_OP_BANG: k = K_NOT;
      MODE_OP_LT:   k = K_LT;
      MODE_OP_GT:   k = K_GT;
      default:      k = K_ILLEGAL;
    endcase
    return k;
  endfunction

  function automatic kind_t op_double_kind(input mode_t m);
    kind_t k;
    unique case (m)
      MODE_OP_EQ:   k = K_EQ;
      MODE_OP_BANG: k = K_NE;
      MODE_OP_LT:   k = K_LE;
      MODE_OP_GT:   k = K_GE;
      MODE_OP_AMP:  k = K_AND;
      default:      k = K_OR;
    endcase
    return k;
  endfunction

  // Keyword match; word byte j sits at bits [8j+:8]
  function automatic kind_t kw_lookup(input logic [8*KW_SPELL_MAX-1:0] word,
                                      input logic [LEN_BITS-1:0] len);
    kind_t                       k;
    logic                        hit;
    logic [8*KW_SPELL_MAX-1:0]   txt;
    k = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      // left-justify so that character j lands at a fixed place
      txt = KW_TEXT[i] << (8 * (KW_SPELL_MAX - KW_LEN[i]));
      hit = (len == LEN_BITS'(KW_LEN[i]));
      for (int j = 0; j < KW_SPELL_MAX; j++) begin
        if (j < KW_LEN[i] && word[8*j +: 8] != txt[8*(KW_SPELL_MAX-1-j) +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit && k == K_IDENT) begin
        k = KW_KIND[i];
      end
    end
    return k;
  endfunction

endpackage

### rtl/core/stt_scan.sv
`timescale 1ns / 1ps

module stt_scan #(
  parameter int OFFSET_BITS     = 16,
  parameter int KEYWORD_MAX_LEN = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  stt_pkg::byte_t        text_byte,
  input  logic                  end_of_text,
  output logic                  push,
  output stt_pkg::rec_t         rec
);
  import stt_pkg::*;

  localparam int IDX_BITS = $clog2(KEYWORD_MAX_LEN);

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] begin_r, begin_nxt;
  logic [LEN_BITS-1:0]    count_r, count_nxt;
  logic                   long_r, long_nxt;
  byte_t                  word_r [KEYWORD_MAX_LEN];

  logic                   wr_en;
  logic [IDX_BITS-1:0]    wr_idx;
  logic [8*KW_SPELL_MAX-1:0] word_flat;
  logic [OFFSET_BITS+START_BITS-1:0] pos_ext, begin_ext;
  logic [START_BITS-1:0]  pos16, begin16;
  logic [LEN_BITS-1:0]    count_grown;
  logic                   b_alnum;
  logic                   fl_v, tok_a_v, tok_b_v;
  tok_t                   fl_tok, tok_b;
  kind_t                  word_kind;
  mode_t                  b_op_mode;

  // Offsets truncated or zero-extended to the token start width
  assign pos_ext   = {{START_BITS{1'b0}}, off_r};
  assign begin_ext = {{START_BITS{1'b0}}, begin_r};
  assign pos16     = pos_ext[START_BITS-1:0];
  assign begin16   = begin_ext[START_BITS-1:0];

  assign count_grown = (count_r == LEN_MAX) ? count_r : count_r + LEN_BITS'(1);
  assign b_alnum     = is_letter(text_byte) || is_digit(text_byte);
  assign b_op_mode   = op_mode_of(text_byte);

  // Keyword lookup over the buffered head of the identifier
  always_comb begin
    for (int j = 0; j < KW_SPELL_MAX; j++) begin
      word_flat[8*j +: 8] = word_r[j];
    end
  end

  assign word_kind = (long_r || count_r > LEN_BITS'(KEYWORD_MAX_LEN)) ? K_IDENT :
                     kw_lookup(word_flat, count_r);

  // Token that the pending mode yields when a byte ends it
  always_comb begin
    fl_v         = (mode_r != MODE_IDLE);
    fl_tok.start = begin16;
    fl_tok.len   = count_r;
    unique case (mode_r)
      MODE_WORD: fl_tok.kind = word_kind;
      MODE_INT:  fl_tok.kind = K_INT_LIT;
      MODE_FRAC: fl_tok.kind = K_FLOAT_LIT;
      default: begin
        fl_tok.kind = op_single_kind(mode_r);
        fl_tok.len  = LEN_BITS'(1);
      end
    endcase
  end

  // Next state and tokens for the accepted byte
  always_comb begin
    mode_nxt  = mode_r;
    off_nxt   = off_r;
    begin_nxt = begin_r;
    count_nxt = count_r;
    long_nxt  = long_r;
    wr_en     = 1'b0;
    wr_idx    = count_r[IDX_BITS-1:0];
    tok_a_v   = 1'b0;
    tok_b_v   = 1'b0;
    tok_b     = '{kind: K_END, start: pos16, len: '0};
    if (take) begin
      if (end_of_text) begin
        tok_a_v  = fl_v;
        tok_b_v  = 1'b1;
        mode_nxt = MODE_IDLE;
        off_nxt  = '0;
      end else if (mode_r == MODE_WORD && b_alnum) begin
        if (count_r < LEN_BITS'(KEYWORD_MAX_LEN)) begin
          wr_en = 1'b1;
        end else begin
          long_nxt = 1'b1;
        end
        count_nxt = count_grown;
        off_nxt   = off_r + OFFSET_BITS'(1);
      end else if ((mode_r == MODE_INT || mode_r == MODE_FRAC) &&
                   (is_digit(text_byte) || (mode_r == MODE_INT && text_byte == CH_DOT))) begin
        if (text_byte == CH_DOT) begin
          mode_nxt = MODE_FRAC;
        end
        count_nxt = count_grown;
        off_nxt   = off_r + OFFSET_BITS'(1);
      end else if (is_op_mode(mode_r) && text_byte == op_second(mode_r)) begin
        tok_b_v  = 1'b1;
        tok_b    = '{kind: op_double_kind(mode_r), start: begin16, len: LEN_BITS'(2)};
        mode_nxt = MODE_IDLE;
        off_nxt  = off_r + OFFSET_BITS'(1);
      end else begin
        // pending token ends here; the byte starts fresh
        tok_a_v  = fl_v;
        mode_nxt = MODE_IDLE;
        off_nxt  = off_r + OFFSET_BITS'(1);
        if (text_byte == CH_NUL) begin
          tok_b_v = 1'b1;
          off_nxt = '0;
        end else if (is_space(text_byte)) begin
          tok_b_v = 1'b0;
        end else if (b_alnum) begin
          begin_nxt = off_r;
          count_nxt = LEN_BITS'(1);
          if (is_digit(text_byte)) begin
            mode_nxt = MODE_INT;
          end else begin
            wr_en    = 1'b1;
            wr_idx   = '0;
            long_nxt = 1'b0;
            mode_nxt = MODE_WORD;
          end
        end else if (b_op_mode != MODE_IDLE) begin
          begin_nxt = off_r;
          count_nxt = LEN_BITS'(1);
          mode_nxt  = b_op_mode;
        end else begin
          tok_b_v = 1'b1;
          tok_b   = '{kind: single_op_kind(text_byte), start: pos16, len: LEN_BITS'(1)};
        end
      end
    end
  end

  // Pack into a queue record, first token in slot zero
  assign push    = tok_a_v || tok_b_v;
  assign rec.t0  = tok_a_v ? fl_tok : tok_b;
  assign rec.t1  = tok_b;
  assign rec.two = tok_a_v && tok_b_v;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // Position and length counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      begin_r <= '0;
      count_r <= '0;
      long_r  <= 1'b0;
    end else begin
      off_r   <= off_nxt;
      begin_r <= begin_nxt;
      count_r <= count_nxt;
      long_r  <= long_nxt;
    end
  end

  // Identifier head buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_r[wr_idx] <= text_byte;
    end
  end

endmodule

### rtl/core/stt_queue.sv
`timescale 1ns / 1ps

module stt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  stt_pkg::rec_t push_rec,
  input  logic          pop,
  output stt_pkg::rec_t head,
  output logic          empty,
  output logic          full
);
  import stt_pkg::*;

  rec_t                  mem_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_BITS:0]   cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + Q_PTR_BITS'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (Q_PTR_BITS+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (Q_PTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Record storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

### rtl/core/stt_emit.sv
`timescale 1ns / 1ps

module stt_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  stt_pkg::rec_t                       head,
  input  logic                                empty,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [stt_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  output logic                                out_tlast
);
  import stt_pkg::*;

  logic valid_r, valid_nxt;
  logic sel_r, sel_nxt;
  tok_t tok_r, tok_nxt;
  logic last_r, last_nxt;
  logic load;
  logic split;

  // Output register free, or its token taken this cycle
  assign load  = !valid_r || out_tready;
  assign split = head.two && !sel_r;

  // Walk the head record one token per transfer
  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    tok_nxt   = tok_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) begin
        tok_nxt  = sel_r ? head.t1 : head.t0;
        last_nxt = !split;
        if (split) begin
          sel_nxt = 1'b1;
        end else begin
          sel_nxt = 1'b0;
          pop     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {{(OUT_DATA_BITS-KIND_BITS-START_BITS-LEN_BITS){1'b0}},
                       tok_r.len, tok_r.start, tok_r.kind};

endmodule

### rtl/core/source_text_tokenizer.sv
`timescale 1ns / 1ps
// Channel   Dir  Transfer moves                   Ports
// in_       in   one source byte or end mark      in_tvalid/in_tready/in_tdata/in_tuser
// out_      out  one token                        out_tvalid/out_tready/out_tdata/out_tlast
//
// One byte is taken per cycle while the four-record token queue has room.
// Tokens leave at one per cycle while out_tready is high; a byte that closes a
// token and makes its own yields two tokens, so the output port sets the rate on such text.
// After its byte's transfer, a token is written to the queue and then loaded into the output register.
// Reset (rst_n low, synchronous) clears scanner mode, offset, queue and output.
// With out_tready low the queue fills and then in_tready drops.

module source_text_tokenizer #(
  parameter int OFFSET_BITS     = 16,
  parameter int KEYWORD_MAX_LEN = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [stt_pkg::IN_DATA_BITS-1:0]   in_tdata,   // [7:0] text_byte
  input  logic                               in_tuser,   // [0] end_of_text
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [stt_pkg::OUT_DATA_BITS-1:0]  out_tdata,  // [5:0] token_kind,
                                                         // [21:6] token_start,
                                                         // [37:22] token_length
  output logic                               out_tlast   // last_of_run
);
  import stt_pkg::*;

  logic take;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  rec_t push_rec;
  rec_t head;

  assign in_tready = !q_full;
  assign take      = in_tvalid && in_tready;

  // Front: byte classification and token assembly
  stt_scan #(
    .OFFSET_BITS     (OFFSET_BITS),
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .text_byte   (in_tdata[BYTE_BITS-1:0]),
    .end_of_text (in_tuser),
    .push        (push),
    .rec         (push_rec)
  );

  // Decoupling queue
  stt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: token serializer and output register
  stt_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/core/stt_checker.sv
`timescale 1ns / 1ps

module stt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [stt_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  input logic                               out_tlast
);
  import stt_pkg::*;

  // Nothing left on the output after reset
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Stalled token holds
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("token changed while stalled");

  // Kind within the defined set
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:0] <= KIND_LAST)
    else $error("token kind out of range");

  // End token is empty and closes its run
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5:0] == K_END |-> out_tdata[37:22] == '0 && out_tlast)
    else $error("malformed end token");

  // Every other token covers at least one byte
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5:0] != K_END |-> out_tdata[37:22] != '0)
    else $error("empty token");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import stt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_MAX   = 40;

  typedef logic [8*KW_SPELL_MAX-1:0] spell_t;

  // One source byte as offered to the block
  typedef struct packed {
    byte_t text;
    logic  eot;
    logic  burst;  // offered with no gap after the previous byte
  } char_t;

  typedef struct packed {
    kind_t                 kind;
    logic [START_BITS-1:0] start;
    logic [LEN_BITS-1:0]   len;
    logic                  last;
  } token_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata   = '0;
  logic                     in_tuser   = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tlast;

  char_t  text_queue[$];
  token_t tokens_due[$];
  token_t want_tok;
  char_t  cur_char   = '0;
  int     errors     = 0;
  int     cycles     = 0;
  int     n_taken    = 0;
  int     n_checked  = 0;
  int     step_count = 0;
  bit     in_took    = 1'b0;
  bit     out_took   = 1'b0;

  // Scanner state of the predictor
  mode_t                 lex_mode  = MODE_IDLE;
  logic [START_BITS-1:0] lex_pos   = '0;
  logic [START_BITS-1:0] lex_begin = '0;
  logic [LEN_BITS-1:0]   lex_len   = '0;
  spell_t                lex_word  = '0;
  logic                  lex_long  = 1'b0;

  source_text_tokenizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic alpha_char(input byte_t b);
    return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z) || b == CH_UNDER;
  endfunction

  function automatic logic num_char(input byte_t b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic blank_char(input byte_t b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // Keyword or identifier; w holds the first bytes, oldest in the high end
  function automatic kind_t word_class(input spell_t w, input logic [LEN_BITS-1:0] n,
                                       input logic too_long);
    if (too_long || n > KW_SPELL_MAX) return K_IDENT;
    case (w)
      spell_t'("int"):     return K_KW_INT;
      spell_t'("float"):   return K_KW_FLOAT;
      spell_t'("char"):    return K_KW_CHAR;
      spell_t'("bool"):    return K_KW_BOOL;
      spell_t'("varchar"): return K_KW_VARCHR;
      spell_t'("vi"):      return K_KW_VI;
      spell_t'("void"):    return K_KW_VOID;
      spell_t'("for"):     return K_KW_FOR;
      spell_t'("forn"):    return K_KW_FOR;
      spell_t'("while"):   return K_KW_WHILE;
      spell_t'("if"):      return K_KW_IF;
      spell_t'("else"):    return K_KW_ELSE;
      spell_t'("return"):  return K_KW_RETURN;
      spell_t'("true"):    return K_KW_TRUE;
      spell_t'("false"):   return K_KW_FALSE;
      default:             return K_IDENT;
    endcase
  endfunction

  // Characters that wait for a possible second character
  function automatic mode_t pair_mode(input byte_t b);
    case (b)
      CH_EQUAL: return MODE_OP_EQ;
      CH_BANG:  return MODE_OP_BANG;
      CH_LT:    return MODE_OP_LT;
      CH_GT:    return MODE_OP_GT;
      CH_AMP:   return MODE_OP_AMP;
      CH_BAR:   return MODE_OP_BAR;
      default:  return MODE_IDLE;
    endcase
  endfunction

  function automatic kind_t pair_kind(input mode_t m, input logic doubled);
    case (m)
      MODE_OP_EQ:   return doubled ? K_EQ : K_ASSIGN;
      MODE_OP_BANG: return doubled ? K_NE : K_NOT;
      MODE_OP_LT:   return doubled ? K_LE : K_LT;
      MODE_OP_GT:   return doubled ? K_GE : K_GT;
      MODE_OP_AMP:  return doubled ? K_AND : K_ILLEGAL;
      default:      return doubled ? K_OR : K_ILLEGAL;
    endcase
  endfunction

  task automatic emit(input kind_t k, input logic [START_BITS-1:0] at,
                      input logic [LEN_BITS-1:0] n);
    tokens_due.push_back(token_t'{k, at, n, 1'b0});
    step_count++;
  endtask

  // Emit whatever token is pending and go idle
  task automatic close_pending();
    case (lex_mode)
      MODE_IDLE: ;
      MODE_WORD: emit(word_class(lex_word, lex_len, lex_long), lex_begin, lex_len);
      MODE_INT:  emit(K_INT_LIT, lex_begin, lex_len);
      MODE_FRAC: emit(K_FLOAT_LIT, lex_begin, lex_len);
      default:   emit(pair_kind(lex_mode, 1'b0), lex_begin, 16'd1);
    endcase
    lex_mode = MODE_IDLE;
  endtask

  // Tokens caused by one accepted byte or end mark
  task automatic lex_step(input byte_t b, input logic eot);
    logic [START_BITS-1:0] at;
    logic                  absorbed;
    byte_t                 pair_second;
    kind_t                 k;
    token_t                last_tok;
    at         = lex_pos;
    absorbed   = 1'b0;
    step_count = 0;
    if (eot) begin
      close_pending();
      emit(K_END, at, '0);
      lex_pos = '0;
    end else begin
      pair_second = (lex_mode == MODE_OP_AMP) ? CH_AMP :
                    (lex_mode == MODE_OP_BAR) ? CH_BAR : CH_EQUAL;
      // bytes that extend the pending token
      case (lex_mode)
        MODE_IDLE: ;
        MODE_WORD: if (alpha_char(b) || num_char(b)) begin
          if (lex_len < KW_SPELL_MAX) lex_word = {lex_word[8*KW_SPELL_MAX-9:0], b};
          else lex_long = 1'b1;
          if (lex_len != LEN_MAX) lex_len++;
          absorbed = 1'b1;
        end
        MODE_INT, MODE_FRAC: if (num_char(b) || (lex_mode == MODE_INT && b == CH_DOT)) begin
          if (b == CH_DOT) lex_mode = MODE_FRAC;
          if (lex_len != LEN_MAX) lex_len++;
          absorbed = 1'b1;
        end
        default: if (b == pair_second) begin
          emit(pair_kind(lex_mode, 1'b1), lex_begin, 16'd2);
          lex_mode = MODE_IDLE;
          absorbed = 1'b1;
        end
      endcase
      lex_pos = at + 1'b1;
      // byte ends the pending token and is looked at on its own
      if (!absorbed) begin
        close_pending();
        if (b == CH_NUL) begin
          emit(K_END, at, '0);
          lex_pos = '0;
        end else if (alpha_char(b) || num_char(b)) begin
          lex_begin = at;
          lex_len   = 16'd1;
          if (num_char(b)) begin
            lex_mode = MODE_INT;
          end else begin
            lex_word = spell_t'(b);
            lex_long = 1'b0;
            lex_mode = MODE_WORD;
          end
        end else if (pair_mode(b) != MODE_IDLE) begin
          lex_begin = at;
          lex_len   = 16'd1;
          lex_mode  = pair_mode(b);
        end else if (!blank_char(b)) begin
          case (b)
            CH_PLUS:   k = K_PLUS;
            CH_MINUS:  k = K_MINUS;
            CH_SLASH:  k = K_DIV;
            CH_STAR:   k = K_MUL;
            CH_SEMI:   k = K_SEMI;
            CH_COMMA:  k = K_COMMA;
            CH_COLON:  k = K_COLON;
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_LBRACK: k = K_LBRACKET;
            CH_RBRACK: k = K_RBRACKET;
            default:   k = K_ILLEGAL;
          endcase
          emit(k, at, 16'd1);
        end
      end
    end
    // flag the final token of this step
    if (step_count > 0) begin
      last_tok      = tokens_due.pop_back();
      last_tok.last = 1'b1;
      tokens_due.push_back(last_tok);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add_byte(input byte_t b, input logic eot, input logic burst);
    text_queue.push_back(char_t'{b, eot, burst});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(byte_t'(s[i]), 1'b0, 1'b0);
  endtask

  function automatic byte_t rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return CH_LO_A + byte_t'(r);
    if (r < 52) return CH_UP_A + byte_t'(r - 26);
    return CH_UNDER;
  endfunction

  function automatic byte_t rand_digit();
    return CH_ZERO + byte_t'($urandom_range(0, 9));
  endfunction

  function automatic byte_t rand_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + byte_t'(r);
  endfunction

  // Mostly well-formed tokens, with some noise, NULs and end marks
  task automatic add_random_token();
    int n;
    case ($urandom_range(0, 12))
      0, 1, 2: begin
        case ($urandom_range(0, 14))
          0:  add_text("int");
          1:  add_text("float");
          2:  add_text("char");
          3:  add_text("bool");
          4:  add_text("varchar");
          5:  add_text("vi");
          6:  add_text("void");
          7:  add_text("for");
          8:  add_text("forn");
          9:  add_text("while");
          10: add_text("if");
          11: add_text("else");
          12: add_text("return");
          13: add_text("true");
          default: add_text("false");
        endcase
        // near miss: one more character
        if ($urandom_range(0, 3) == 0)
          add_byte($urandom_range(0, 1) ? rand_letter() : rand_digit(), 1'b0, 1'b0);
      end
      3, 4: begin
        n = $urandom_range(1, 12);
        add_byte(rand_letter(), 1'b0, 1'b0);
        repeat (n - 1)
          add_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter(), 1'b0, 1'b0);
      end
      5: repeat ($urandom_range(1, 5)) add_byte(rand_digit(), 1'b0, 1'b0);
      6: begin
        repeat ($urandom_range(1, 3)) add_byte(rand_digit(), 1'b0, 1'b0);
        add_byte(CH_DOT, 1'b0, 1'b0);
        repeat ($urandom_range(0, 3)) add_byte(rand_digit(), 1'b0, 1'b0);
        if ($urandom_range(0, 3) == 0) add_byte(CH_DOT, 1'b0, 1'b0);
      end
      7, 8, 9: begin
        case ($urandom_range(0, 24))
          0:  add_text("=");   1:  add_text("==");  2:  add_text("+");
          3:  add_text("-");   4:  add_text("!");   5:  add_text("!=");
          6:  add_text("/");   7:  add_text("*");   8:  add_text("<");
          9:  add_text("<=");  10: add_text(">");   11: add_text(">=");
          12: add_text("&&");  13: add_text("||");  14: add_text(";");
          15: add_text(",");   16: add_text(":");   17: add_text("(");
          18: add_text(")");   19: add_text("{");   20: add_text("}");
          21: add_text("[");   22: add_text("]");   23: add_text("&");
          default: add_text("|");
        endcase
      end
      10: add_byte(rand_blank(), 1'b0, 1'b0);
      11: add_byte(byte_t'($urandom_range(0, 255)), 1'b0, 1'b0);
      default: begin
        if ($urandom_range(0, 2) == 0) add_byte(CH_NUL, 1'b0, 1'b0);
        else add_byte(byte_t'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
    endcase
    if ($urandom_range(0, 1) == 1) add_byte(rand_blank(), 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------- sender

  int in_gap         = 0;
  int in_calm        = 0;
  bit in_tvalid_hold = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      // previous byte went through: draw the wait before the next one
      if (in_took) begin
        in_took   = 1'b0;
        if (in_calm > 0) in_calm--;
        else if ($urandom_range(0, 39) == 0) in_calm = 30;
        in_gap = (cur_char.burst || in_calm > 0) ? 0 : $urandom_range(0, 9);
        in_tvalid_hold = 1'b0;
      end
      if (!in_tvalid_hold) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (text_queue.size() > 0) begin
          cur_char       = text_queue.pop_front();
          in_tvalid_hold = 1'b1;
        end
      end
      in_tvalid <= in_tvalid_hold;
      in_tdata  <= cur_char.text;
      in_tuser  <= cur_char.eot;
    end
  end

  // ---------------------------------------------------------------- receiver

  int out_gap   = 0;
  int out_calm  = 0;
  int hold_left = 0;
  bit held      = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) begin
        out_took = 1'b0;
        if (out_calm > 0) out_calm--;
        else if ($urandom_range(0, 39) == 0) out_calm = 30;
        out_gap = (out_calm > 0) ? 0 : $urandom_range(0, 9);
      end
      // one long hold-off so the token queue fills and input stalls
      if (!held && n_taken >= 40) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report(input string msg);
    if (errors < PRINT_MAX) $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      lex_step(in_tdata, in_tuser);
      in_took = 1'b1;
      n_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      out_took = 1'b1;
      if (tokens_due.size() == 0) begin
        report($sformatf("token %h with none expected", out_tdata));
      end else begin
        want_tok = tokens_due.pop_front();
        if (out_tdata[KIND_BITS-1:0] != want_tok.kind)
          report($sformatf("token %0d kind %0d, expected %0d", n_checked,
                           out_tdata[KIND_BITS-1:0], want_tok.kind));
        if (out_tdata[KIND_BITS +: START_BITS] != want_tok.start)
          report($sformatf("token %0d start %0d, expected %0d", n_checked,
                           out_tdata[KIND_BITS +: START_BITS], want_tok.start));
        if (out_tdata[KIND_BITS+START_BITS +: LEN_BITS] != want_tok.len)
          report($sformatf("token %0d length %0d, expected %0d", n_checked,
                           out_tdata[KIND_BITS+START_BITS +: LEN_BITS], want_tok.len));
        if (out_tlast != want_tok.last)
          report($sformatf("token %0d tlast %b, expected %b", n_checked,
                           out_tlast, want_tok.last));
      end
      n_checked++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** source_text_tokenizer: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main

  int mark;

  initial begin
    // keywords at full length, identifier forms, number and dot rules,
    // pair operators, high bytes, NUL, pending operators at the end mark
    add_text("varchar forn _Z9 0..7e!= .");
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(CH_NUL, 1'b0, 1'b0);
    add_text("<");
    add_byte(8'hA5, 1'b1, 1'b0);
    add_text("|&");
    add_byte(8'h5A, 1'b1, 1'b0);

    while (text_queue.size() < 300) add_random_token();

    // long identifier, well past the keyword buffer, sent back to back
    add_byte(rand_letter(), 1'b0, 1'b1);
    repeat (20)
      add_byte(($urandom_range(0, 4) == 0) ? rand_digit() : rand_letter(), 1'b0, 1'b1);
    add_text("+1");
    add_byte(8'h00, 1'b1, 1'b0);

    mark = text_queue.size();
    while (text_queue.size() < mark + 170) add_random_token();
    add_byte(8'hC3, 1'b1, 1'b0);

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (text_queue.size() > 0 || in_tvalid || tokens_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("** source_text_tokenizer: PASSED **");
    end else begin
      $display("** source_text_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule
